/* rtl/core/lerf_pkg.sv */
// ----------------------------------------------------------------------------
// lerf_pkg
// shared types and constants for the line edit receive fifo
// ----------------------------------------------------------------------------
`default_nettype none

package lerf_pkg;

  // default ring depth, legal range 2..256
  localparam int unsigned BufferDepthDefault = 32;

  // character width
  localparam int unsigned CharW = 8;

  // operation codes of the input transfer
  typedef enum logic [1:0] {
    OpReceive = 2'd0,
    OpPop     = 2'd1,
    OpClear   = 2'd2,
    OpSetEcho = 2'd3
  } op_e;

  // control characters
  localparam logic [CharW-1:0] ChNul = 8'd0;
  localparam logic [CharW-1:0] ChBel = 8'd7;
  localparam logic [CharW-1:0] ChBs  = 8'd8;
  localparam logic [CharW-1:0] ChLf  = 8'd10;
  localparam logic [CharW-1:0] ChCr  = 8'd13;
  localparam logic [CharW-1:0] ChDel = 8'd127;
  localparam logic [CharW-1:0] ChPrintLo = 8'd32;
  localparam logic [CharW-1:0] ChPrintHi = 8'd126;

endpackage

`default_nettype wire

/* rtl/core/line_edit_receive_fifo_unit.sv */
// ----------------------------------------------------------------------------
// line_edit_receive_fifo_unit
// terminal receive front end with line editing, echo decision and a
// character ring kept in a synchronous memory
// ----------------------------------------------------------------------------
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+--------------------------------------
//  input   | in_valid_i | in_stall_o  | operation_i rx_byte_i tx_ready_i
//          |            |             | echo_value_i
//  output  | out_valid_o| out_stall_i | echo_valid_o echo_byte_o
//          |            |             | popped_byte_o pop_empty_o line_ready_o
//          |            |             | echo_enabled_o buffer_full_o
//
//  receive, clear, set echo and a pop on an empty ring load their result
//  straight into the output register; a pop that returns a character first
//  reads the registered memory port, and the next transfer waits for it
//  a new input transfer is taken in the cycle the old result leaves, so a
//  free output with no pop read pending gives one item a cycle
//  reset clears pointers and flags only, the character memory is not swept
//  a stall on the output holds the result and stalls the input side
//
`default_nettype none

module line_edit_receive_fifo_unit #(
  parameter int unsigned BufferDepth = lerf_pkg::BufferDepthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 operation_i,
  input  wire logic [lerf_pkg::CharW-1:0] rx_byte_i,
  input  wire logic                       tx_ready_i,
  input  wire logic                       echo_value_i,
  // output channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            echo_valid_o,
  output logic      [lerf_pkg::CharW-1:0] echo_byte_o,
  output logic      [lerf_pkg::CharW-1:0] popped_byte_o,
  output logic                            pop_empty_o,
  output logic                            line_ready_o,
  output logic                            echo_enabled_o,
  output logic                            buffer_full_o
);

  localparam int unsigned AW = $clog2(BufferDepth);
  localparam logic [AW-1:0] LastIdx = AW'(BufferDepth - 1);

  // ring pointer step with wrap at any depth
  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - AW'(1);
  endfunction

  // --------------------------------------------------------------------------
  // architectural state
  // --------------------------------------------------------------------------
  logic [AW-1:0]              head_q, head_d;
  logic [AW-1:0]              tail_q, tail_d;
  logic                       full_q, full_d;
  logic                       bs_blocked_q, bs_blocked_d;
  logic                       echo_on_q, echo_on_d;
  logic                       line_done_q, line_done_d;
  logic [lerf_pkg::CharW-1:0] prev_byte_q, prev_byte_d;

  // read of the ring is in flight, result waits for memory data
  logic rd_pend_q, rd_pend_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       res_echo_valid_q, res_echo_valid_d;
  logic [lerf_pkg::CharW-1:0] res_echo_byte_q, res_echo_byte_d;
  logic [lerf_pkg::CharW-1:0] res_popped_q, res_popped_d;
  logic                       res_pop_empty_q, res_pop_empty_d;
  logic                       res_line_q, res_line_d;
  logic                       res_echo_en_q, res_echo_en_d;
  logic                       res_full_q, res_full_d;

  // memory ports
  logic                       wr_en;
  logic [lerf_pkg::CharW-1:0] rd_data;
  logic                       rd_en;

  logic out_blocked;
  logic in_xfer;
  logic out_load;

  // output register cannot take a new result while the old one is stalled
  assign out_blocked = out_valid_q & out_stall_i;
  assign in_stall_o  = rd_pend_q | out_blocked;
  assign in_xfer     = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // step logic: next state and result of the accepted transfer
  // --------------------------------------------------------------------------
  logic                       is_bs;
  logic                       is_echoable;
  logic                       full_tmp;
  logic                       echo_hit;
  logic [lerf_pkg::CharW-1:0] echo_chr;
  logic                       pop_empty;

  assign is_bs = (rx_byte_i == lerf_pkg::ChBs) || (rx_byte_i == lerf_pkg::ChDel);
  assign is_echoable = ((rx_byte_i >= lerf_pkg::ChPrintLo) && (rx_byte_i <= lerf_pkg::ChPrintHi))
                    || (rx_byte_i == lerf_pkg::ChBel) || (rx_byte_i == lerf_pkg::ChCr)
                    || (rx_byte_i == lerf_pkg::ChLf);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    full_d       = full_q;
    bs_blocked_d = bs_blocked_q;
    echo_on_d    = echo_on_q;
    line_done_d  = line_done_q;
    prev_byte_d  = prev_byte_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    full_tmp     = full_q;
    echo_hit     = 1'b0;
    echo_chr     = '0;
    pop_empty    = 1'b0;

    unique case (lerf_pkg::op_e'(operation_i))
      lerf_pkg::OpReceive: begin
        if (rx_byte_i == lerf_pkg::ChNul) begin
          // nul toggles echo, nothing stored
          echo_on_d = ~echo_on_q;
        end else if ((rx_byte_i == lerf_pkg::ChLf) && (prev_byte_q == lerf_pkg::ChCr)) begin
          // lf right after cr is swallowed
        end else begin
          if ((rx_byte_i == lerf_pkg::ChCr) || (rx_byte_i == lerf_pkg::ChLf)) begin
            line_done_d = 1'b1;
          end
          if (is_bs) begin
            // delete newest entry
            if (head_q != tail_q) begin
              head_d = ring_prev(head_q);
              full_d = 1'b0;
            end
          end else begin
            if (full_q && (ring_next(head_q) != tail_q)) begin
              full_tmp = 1'b0;
            end
            full_d = full_tmp;
            if (!full_tmp) begin
              // last free slot is written but head holds
              wr_en = 1'b1;
              if (ring_next(head_q) == tail_q) begin
                full_d = 1'b1;
              end else begin
                head_d = ring_next(head_q);
              end
            end
          end
        end
        // echo decision on the updated state
        if (echo_on_d && tx_ready_i) begin
          if (is_echoable) begin
            echo_hit     = 1'b1;
            echo_chr     = full_d ? lerf_pkg::ChBel : rx_byte_i;
            bs_blocked_d = 1'b0;
          end else if (is_bs) begin
            echo_hit = 1'b1;
            if (head_d == tail_q) begin
              // guard repeated backspace on an empty line
              if (!bs_blocked_q) begin
                bs_blocked_d = 1'b1;
                echo_chr     = rx_byte_i;
              end else begin
                echo_chr = lerf_pkg::ChBel;
              end
            end else begin
              echo_chr = rx_byte_i;
            end
          end
        end
        prev_byte_d = rx_byte_i;
      end
      lerf_pkg::OpPop: begin
        if (head_q == tail_q) begin
          pop_empty = 1'b1;
        end else begin
          rd_en  = 1'b1;
          tail_d = ring_next(tail_q);
        end
      end
      lerf_pkg::OpClear: begin
        head_d       = '0;
        tail_d       = '0;
        full_d       = 1'b0;
        line_done_d  = 1'b0;
        bs_blocked_d = 1'b1;
      end
      lerf_pkg::OpSetEcho: begin
        echo_on_d = echo_value_i;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result staging
  // --------------------------------------------------------------------------
  always_comb begin
    rd_pend_d        = rd_pend_q;
    out_valid_d      = out_valid_q & out_stall_i;
    out_load         = 1'b0;
    res_echo_valid_d = res_echo_valid_q;
    res_echo_byte_d  = res_echo_byte_q;
    res_popped_d     = res_popped_q;
    res_pop_empty_d  = res_pop_empty_q;
    res_line_d       = res_line_q;
    res_echo_en_d    = res_echo_en_q;
    res_full_d       = res_full_q;

    if (rd_pend_q && !out_blocked) begin
      // memory data for the pop is here
      out_load         = 1'b1;
      rd_pend_d        = 1'b0;
      res_echo_valid_d = 1'b0;
      res_echo_byte_d  = '0;
      res_popped_d     = rd_data;
      res_pop_empty_d  = 1'b0;
      res_line_d       = line_done_q;
      res_echo_en_d    = echo_on_q;
      res_full_d       = full_q;
    end else if (in_xfer && rd_en) begin
      rd_pend_d = 1'b1;
    end else if (in_xfer) begin
      out_load         = 1'b1;
      res_echo_valid_d = echo_hit;
      res_echo_byte_d  = echo_chr;
      res_popped_d     = '0;
      res_pop_empty_d  = pop_empty;
      res_line_d       = line_done_d;
      res_echo_en_d    = echo_on_d;
      res_full_d       = full_d;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      full_q       <= 1'b0;
      bs_blocked_q <= 1'b0;
      echo_on_q    <= 1'b1;
      line_done_q  <= 1'b0;
      prev_byte_q  <= '0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        head_q       <= head_d;
        tail_q       <= tail_d;
        full_q       <= full_d;
        bs_blocked_q <= bs_blocked_d;
        echo_on_q    <= echo_on_d;
        line_done_q  <= line_done_d;
        prev_byte_q  <= prev_byte_d;
      end
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    res_echo_valid_q <= res_echo_valid_d;
    res_echo_byte_q  <= res_echo_byte_d;
    res_popped_q     <= res_popped_d;
    res_pop_empty_q  <= res_pop_empty_d;
    res_line_q       <= res_line_d;
    res_echo_en_q    <= res_echo_en_d;
    res_full_q       <= res_full_d;
  end

  // --------------------------------------------------------------------------
  // character memory
  // --------------------------------------------------------------------------
  lerf_char_ram #(
    .Depth (BufferDepth)
  ) u_char_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_xfer & wr_en),
    .wr_addr_i (head_q),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (in_xfer & rd_en),
    .rd_addr_i (tail_q),
    .rd_data_o (rd_data)
  );

  assign out_valid_o    = out_valid_q;
  assign echo_valid_o   = res_echo_valid_q;
  assign echo_byte_o    = res_echo_byte_q;
  assign popped_byte_o  = res_popped_q;
  assign pop_empty_o    = res_pop_empty_q;
  assign line_ready_o   = res_line_q;
  assign echo_enabled_o = res_echo_en_q;
  assign buffer_full_o  = res_full_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // no input transfer is taken while a pop read is in flight
  a_pend_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> in_stall_o)
    else $error("input not stalled during pending pop");

  // pending pop read lands in the output register as soon as it is free
  a_pop_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && !out_blocked) |=> (!rd_pend_q && out_valid_q))
    else $error("pending pop did not complete");

  // a result without echo carries a zero echo byte
  a_echo_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_echo_valid_q) |-> (res_echo_byte_q == '0))
    else $error("echo byte nonzero without echo");

  // an empty pop returns zero
  a_pop_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_pop_empty_q) |-> (res_popped_q == '0))
    else $error("empty pop returned data");

endmodule

`default_nettype wire

/* rtl/core/lerf_char_ram.sv */
// ----------------------------------------------------------------------------
// lerf_char_ram
// character store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lerf_char_ram #(
  parameter int unsigned Depth = lerf_pkg::BufferDepthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(Depth)-1:0]   wr_addr_i,
  input  wire logic [lerf_pkg::CharW-1:0] wr_data_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(Depth)-1:0]   rd_addr_i,
  output logic      [lerf_pkg::CharW-1:0] rd_data_o
);

  logic [lerf_pkg::CharW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for line_edit_receive_fifo_unit
// drives receive, pop, clear and set-echo transfers with bursty valid and a
// patterned output stall, predicts every result with a behavioral copy of
// the line editor and compares each output transfer field by field
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned Depth      = lerf_pkg::BufferDepthDefault;
  localparam int unsigned CharW      = lerf_pkg::CharW;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned MaxReports = 30;

  // one output transfer of the block
  typedef struct packed {
    logic             echo_valid;
    logic [CharW-1:0] echo_byte;
    logic [CharW-1:0] popped_byte;
    logic             pop_empty;
    logic             line_ready;
    logic             echo_enabled;
    logic             buffer_full;
  } term_result_t;

  // clock, reset and block ports, all known from time zero
  logic             clk_i;
  logic             rst_ni       = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall_o;
  lerf_pkg::op_e    in_op        = lerf_pkg::OpReceive;
  logic [CharW-1:0] in_byte      = '0;
  logic             in_tx_ready  = 1'b0;
  logic             in_echo_val  = 1'b0;
  logic             out_valid_o;
  logic             out_stall    = 1'b0;
  logic             echo_valid_o;
  logic [CharW-1:0] echo_byte_o;
  logic [CharW-1:0] popped_byte_o;
  logic             pop_empty_o;
  logic             line_ready_o;
  logic             echo_enabled_o;
  logic             buffer_full_o;

  // behavioral copy of the editor state, reset values
  logic [CharW-1:0] ring_chars [Depth];
  int unsigned      ring_head     = 0;
  int unsigned      ring_tail     = 0;
  logic             ring_full     = 1'b0;
  logic             bs_blocked    = 1'b0;
  logic             echo_on       = 1'b1;
  logic             line_done     = 1'b0;
  logic [CharW-1:0] last_rx_byte  = '0;

  // results predicted but not yet seen on the output
  term_result_t     awaited_terminal_results [$];
  term_result_t     oldest_result;

  // bookkeeping
  int unsigned      items_sent      = 0;
  int unsigned      results_checked = 0;
  int unsigned      char_pops       = 0;
  int unsigned      full_ring_hits  = 0;
  int unsigned      bel_echoes      = 0;
  int unsigned      fail_count      = 0;
  int unsigned      cycle_count     = 0;
  int unsigned      burst_left      = 0;

  // receiver stall pattern state
  int unsigned      stall_period = 1;
  int unsigned      stall_duty   = 0;
  int unsigned      stall_phase  = 0;
  int unsigned      stall_age    = 0;

  line_edit_receive_fifo_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .operation_i    (in_op),
    .rx_byte_i      (in_byte),
    .tx_ready_i     (in_tx_ready),
    .echo_value_i   (in_echo_val),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .echo_valid_o   (echo_valid_o),
    .echo_byte_o    (echo_byte_o),
    .popped_byte_o  (popped_byte_o),
    .pop_empty_o    (pop_empty_o),
    .line_ready_o   (line_ready_o),
    .echo_enabled_o (echo_enabled_o),
    .buffer_full_o  (buffer_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ring index one slot on, wrapping at the depth
  function automatic int unsigned ring_next(input int unsigned idx);
    return (idx == Depth - 1) ? 0 : idx + 1;
  endfunction

  // advances the editor copy by one accepted transfer and returns the result
  // the block must produce for it
  function automatic term_result_t apply_terminal_step(input lerf_pkg::op_e op,
                                                       input logic [CharW-1:0] rx,
                                                       input logic tx_ready,
                                                       input logic echo_value);
    term_result_t res;
    res = '0;
    case (op)
      lerf_pkg::OpReceive: begin
        if (rx == lerf_pkg::ChNul) begin
          // nul flips echo and is never stored
          echo_on = !echo_on;
        end else if (!(rx == lerf_pkg::ChLf && last_rx_byte == lerf_pkg::ChCr)) begin
          // lf right after cr is swallowed, everything else edits the line
          if (rx == lerf_pkg::ChCr || rx == lerf_pkg::ChLf) line_done = 1'b1;
          if (rx == lerf_pkg::ChBs || rx == lerf_pkg::ChDel) begin
            if (ring_head != ring_tail) begin
              ring_head = (ring_head == 0) ? Depth - 1 : ring_head - 1;
              ring_full = 1'b0;
            end
          end else begin
            if (ring_full && ring_next(ring_head) != ring_tail) ring_full = 1'b0;
            if (ring_full) begin
              full_ring_hits++;
            end else begin
              // the last free slot is written but head parks on it
              ring_chars[ring_head] = rx;
              if (ring_next(ring_head) == ring_tail) ring_full = 1'b1;
              else ring_head = ring_next(ring_head);
            end
          end
        end
        if (echo_on && tx_ready) begin
          if ((rx >= lerf_pkg::ChPrintLo && rx <= lerf_pkg::ChPrintHi) ||
              rx == lerf_pkg::ChBel || rx == lerf_pkg::ChCr || rx == lerf_pkg::ChLf) begin
            res.echo_valid = 1'b1;
            res.echo_byte  = ring_full ? lerf_pkg::ChBel : rx;
            bs_blocked     = 1'b0;
          end else if (rx == lerf_pkg::ChBs || rx == lerf_pkg::ChDel) begin
            res.echo_valid = 1'b1;
            if (ring_head != ring_tail) begin
              res.echo_byte = rx;
            end else if (!bs_blocked) begin
              // first backspace on an empty line still erases on screen
              bs_blocked    = 1'b1;
              res.echo_byte = rx;
            end else begin
              res.echo_byte = lerf_pkg::ChBel;
            end
          end
          if (res.echo_valid && res.echo_byte == lerf_pkg::ChBel) bel_echoes++;
        end
        last_rx_byte = rx;
      end
      lerf_pkg::OpPop: begin
        if (ring_head == ring_tail) begin
          res.pop_empty = 1'b1;
        end else begin
          res.popped_byte = ring_chars[ring_tail];
          ring_tail       = ring_next(ring_tail);
          char_pops++;
        end
      end
      lerf_pkg::OpClear: begin
        ring_head  = 0;
        ring_tail  = 0;
        ring_full  = 1'b0;
        line_done  = 1'b0;
        bs_blocked = 1'b1;
      end
      default: begin
        echo_on = echo_value;
      end
    endcase
    res.line_ready   = line_done;
    res.echo_enabled = echo_on;
    res.buffer_full  = ring_full;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // sender side
  // -------------------------------------------------------------------------

  // ends a burst now and then with a random gap; some bursts run long so
  // there are stretches with valid held high
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 15);
    end
  endtask

  // one input transfer; called at a rising edge, returns at the edge where
  // the transfer was taken, after recording what it should produce
  task automatic send_item(input lerf_pkg::op_e op, input logic [CharW-1:0] rx,
                           input logic tx_ready, input logic echo_value);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_byte     <= rx;
    in_tx_ready <= tx_ready;
    in_echo_val <= echo_value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_terminal_results.push_back(apply_terminal_step(op, rx, tx_ready, echo_value));
    items_sent++;
    pace_sender();
  endtask

  // printable character with the transmitter mostly ready
  task automatic type_char();
    send_item(lerf_pkg::OpReceive,
              8'($urandom_range(lerf_pkg::ChPrintLo, lerf_pkg::ChPrintHi)),
              $urandom_range(0, 7) != 0, 1'($urandom));
  endtask

  task automatic type_backspace();
    send_item(lerf_pkg::OpReceive, $urandom_range(0, 1) ? lerf_pkg::ChBs : lerf_pkg::ChDel,
              $urandom_range(0, 7) != 0, 1'($urandom));
  endtask

  task automatic pop_char();
    send_item(lerf_pkg::OpPop, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // -------------------------------------------------------------------------
  // receiver side: stall duty cycle rerolled at random, with
  // free-flowing stretches in between
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      stall_age = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: begin
          stall_period = 1;
          stall_duty   = 0;
        end
        1: begin
          stall_period = 2;
          stall_duty   = 1;
        end
        default: begin
          stall_period = $urandom_range(2, 9);
          stall_duty   = $urandom_range(1, stall_period - 1);
        end
      endcase
    end
    stall_age--;
    stall_phase = (stall_phase + 1) % stall_period;
    out_stall <= (stall_phase < stall_duty);
  end

  // -------------------------------------------------------------------------
  // result checking
  // -------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [CharW-1:0] want,
                             input logic [CharW-1:0] got);
    if (got !== want) begin
      if (fail_count < MaxReports) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (awaited_terminal_results.size() == 0) begin
        if (fail_count < MaxReports) begin
          $error("result transfer with no pending prediction");
        end
        fail_count++;
      end else begin
        oldest_result = awaited_terminal_results.pop_front();
        check_field("echo_valid", CharW'(oldest_result.echo_valid), CharW'(echo_valid_o));
        check_field("echo_byte", oldest_result.echo_byte, echo_byte_o);
        check_field("popped_byte", oldest_result.popped_byte, popped_byte_o);
        check_field("pop_empty", CharW'(oldest_result.pop_empty), CharW'(pop_empty_o));
        check_field("line_ready", CharW'(oldest_result.line_ready), CharW'(line_ready_o));
        check_field("echo_enabled", CharW'(oldest_result.echo_enabled),
                    CharW'(echo_enabled_o));
        check_field("buffer_full", CharW'(oldest_result.buffer_full), CharW'(buffer_full_o));
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_terminal_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // hand-picked sequence: empty pop, backspace guard, nul echo toggle,
  // transmitter busy, field extremes, cr/lf handling, clear and set echo
  task automatic test_directed_editing();
    send_item(lerf_pkg::OpPop, 8'h00, 1'b1, 1'b0);                // pop on an empty ring
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChBs, 1'b1, 1'b0);   // echoed, then guarded
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChDel, 1'b1, 1'b0);  // guarded: bel
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChNul, 1'b1, 1'b0);  // echo off
    send_item(lerf_pkg::OpReceive, 8'h61, 1'b1, 1'b1);            // stored, not echoed
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChNul, 1'b1, 1'b0);  // echo back on
    send_item(lerf_pkg::OpReceive, 8'h41, 1'b0, 1'b0);            // transmitter busy
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChPrintLo, 1'b1, 1'b0);
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChPrintHi, 1'b1, 1'b1);
    send_item(lerf_pkg::OpReceive, 8'hFF, 1'b1, 1'b0);            // stored silently
    send_item(lerf_pkg::OpReceive, 8'h80, 1'b1, 1'b0);
    send_item(lerf_pkg::OpReceive, 8'h1F, 1'b1, 1'b0);
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChBel, 1'b1, 1'b0);
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChCr, 1'b1, 1'b0);   // line complete
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChLf, 1'b1, 1'b0);   // swallowed after cr
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChLf, 1'b1, 1'b0);   // a lone lf is stored
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChDel, 1'b1, 1'b0);
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChBs, 1'b1, 1'b0);
    send_item(lerf_pkg::OpPop, 8'hFF, 1'b0, 1'b1);
    send_item(lerf_pkg::OpPop, 8'h00, 1'b1, 1'b1);
    send_item(lerf_pkg::OpClear, 8'hFF, 1'b1, 1'b1);              // arms the backspace guard
    send_item(lerf_pkg::OpReceive, lerf_pkg::ChBs, 1'b1, 1'b0);
    send_item(lerf_pkg::OpSetEcho, 8'h00, 1'b1, 1'b0);
    send_item(lerf_pkg::OpReceive, 8'h7A, 1'b1, 1'b0);
    send_item(lerf_pkg::OpSetEcho, 8'hFF, 1'b0, 1'b1);
  endtask

  // typed lines with edits and an end of line, then read out or cleared
  task automatic test_line_entry(input int unsigned until_items);
    int unsigned len;
    while (items_sent < until_items) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(lerf_pkg::OpSetEcho, 8'($urandom), 1'($urandom), 1'b1);
      end
      len = $urandom_range(1, 40);
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) type_backspace();
        else type_char();
      end
      case ($urandom_range(0, 3))
        0: send_item(lerf_pkg::OpReceive, lerf_pkg::ChCr, 1'b1, 1'($urandom));
        1: begin
          send_item(lerf_pkg::OpReceive, lerf_pkg::ChCr, 1'b1, 1'($urandom));
          send_item(lerf_pkg::OpReceive, lerf_pkg::ChLf, 1'($urandom), 1'($urandom));
        end
        2: send_item(lerf_pkg::OpReceive, lerf_pkg::ChLf, 1'b1, 1'($urandom));
        default: ;
      endcase
      case ($urandom_range(0, 2))
        0: repeat (len + $urandom_range(0, 3)) pop_char();
        1: send_item(lerf_pkg::OpClear, 8'($urandom), 1'($urandom), 1'($urandom));
        default: repeat ($urandom_range(0, 5)) pop_char();
      endcase
    end
  endtask

  // type close to or past the ring depth, so the ring often fills and overruns,
  // then edit and drain around the full slot
  task automatic test_ring_overflow(input int unsigned until_items);
    while (items_sent < until_items) begin
      send_item(lerf_pkg::OpClear, 8'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 1)) send_item(lerf_pkg::OpSetEcho, 8'($urandom), 1'b1, 1'b1);
      repeat ($urandom_range(Depth - 2, Depth + 8)) type_char();
      repeat ($urandom_range(0, 3)) type_backspace();
      repeat ($urandom_range(1, 4)) pop_char();
      repeat ($urandom_range(1, 6)) type_char();
      if ($urandom_range(0, 1)) type_backspace();
      repeat ($urandom_range(0, Depth + 2)) pop_char();
    end
  endtask

  // unconstrained transfers: every byte, op and flag value
  task automatic test_random_noise(input int unsigned until_items);
    while (items_sent < until_items) begin
      send_item(lerf_pkg::op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom), 1'($urandom));
    end
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_editing();
    test_line_entry(1000);
    test_ring_overflow(1250);
    test_random_noise(1575);

    in_valid <= 1'b0;
    while (awaited_terminal_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d transfers, checked %0d results in %0d cycles", items_sent,
             results_checked, cycle_count);
    $display("popped %0d characters, %0d writes hit a full ring, %0d bel echoes",
             char_pops, full_ring_hits, bel_echoes);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
